// ===== rtl/utf8s_pkg.sv =====
`timescale 1ns / 1ps
// utf8s_pkg: shared types, constants and byte-range checks for the utf8 sanitizer
// used by every rtl module of the block; depends on nothing

package utf8s_pkg;

    localparam int QUEUE_DEPTH = 2;

    // U+FFFD in utf8
    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    // sub-byte positions inside a replacement
    localparam logic [1:0] SUB_B0 = 2'd0;
    localparam logic [1:0] SUB_B1 = 2'd1;
    localparam logic [1:0] SUB_B2 = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_replaced;
        logic       run_last;
        logic       stream_end;
    } out_item_t;

    // one output unit: a literal byte or a whole replacement sequence
    typedef struct packed {
        logic       repl;
        logic [7:0] value;
    } unit_t;

    // everything one input item produces
    typedef struct packed {
        unit_t [3:0] units;
        logic  [2:0] count;
        logic        last;
    } job_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

    // sequence length a lead byte starts, zero when it cannot lead
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        begin
            len = 3'd0;
            if (b < 8'h80)
            begin
                len = 3'd1;
            end
            else if (b >= 8'hC2 && b <= 8'hDF)
            begin
                len = 3'd2;
            end
            else if (b >= 8'hE0 && b <= 8'hEF)
            begin
                len = 3'd3;
            end
            else if (b >= 8'hF0 && b <= 8'hF4)
            begin
                len = 3'd4;
            end
            return len;
        end
    endfunction

    // strict range check for the continuation byte at position pos
    function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] pos,
                                     input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        begin
            lo = 8'h80;
            hi = 8'hBF;
            if (pos == 2'd1)
            begin
                if (lead == 8'hE0)
                begin
                    lo = 8'hA0;
                end
                else if (lead == 8'hED)
                begin
                    hi = 8'h9F;
                end
                else if (lead == 8'hF0)
                begin
                    lo = 8'h90;
                end
                else if (lead == 8'hF4)
                begin
                    hi = 8'h8F;
                end
            end
            return (b >= lo) && (b <= hi);
        end
    endfunction

    function automatic logic [7:0] repl_byte(input logic [1:0] sub);
        logic [7:0] v;
        begin
            case (sub)
                SUB_B0:  v = REPL_B0;
                SUB_B1:  v = REPL_B1;
                default: v = REPL_B2;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== rtl/utf8s_front.sv =====
`timescale 1ns / 1ps
// utf8s_front: accepts input bytes, tracks the pending sequence and builds one job per item
// depends on utf8s_pkg

module utf8s_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  utf8s_pkg::in_item_t item,
    output logic                push,
    output utf8s_pkg::job_t     job
);
    import utf8s_pkg::*;

    logic [7:0] pend_reg [3];
    logic [7:0] pend_next [3];
    logic [1:0] pcount_reg;
    logic [1:0] pcount_next;
    logic [2:0] seqlen_reg;
    logic [2:0] seqlen_next;

    logic [2:0] ucnt;
    logic [2:0] len;
    logic       take;
    logic       ok;

    always_comb
    begin
        job         = '0;
        ucnt        = 3'd0;
        take        = 1'b0;
        pcount_next = pcount_reg;
        seqlen_next = seqlen_reg;
        for (int k = 0; k < 3; k++)
        begin
            pend_next[k] = pend_reg[k];
        end
        len = lead_len(item.in_byte);
        ok  = cont_ok(pend_reg[0], pcount_reg, item.in_byte);

        if (pcount_reg == 2'd0)
        begin
            take = 1'b1;
        end
        else if (ok)
        begin
            if (({1'b0, pcount_reg} + 3'd1) >= seqlen_reg)
            begin
                // sequence complete, pass it through
                for (int k = 0; k < 3; k++)
                begin
                    if (2'(k) < pcount_reg)
                    begin
                        job.units[ucnt[1:0]] = '{repl: 1'b0, value: pend_reg[k]};
                        ucnt = ucnt + 3'd1;
                    end
                end
                job.units[ucnt[1:0]] = '{repl: 1'b0, value: item.in_byte};
                ucnt        = ucnt + 3'd1;
                pcount_next = 2'd0;
                seqlen_next = 3'd0;
            end
            else
            begin
                pend_next[pcount_reg] = item.in_byte;
                pcount_next           = pcount_reg + 2'd1;
            end
        end
        else
        begin
            // each held byte turns into a replacement, then retry as lead
            for (int k = 0; k < 3; k++)
            begin
                if (2'(k) < pcount_reg)
                begin
                    job.units[ucnt[1:0]] = '{repl: 1'b1, value: 8'h00};
                    ucnt = ucnt + 3'd1;
                end
            end
            pcount_next = 2'd0;
            seqlen_next = 3'd0;
            take        = 1'b1;
        end

        if (take)
        begin
            if (len == 3'd0)
            begin
                job.units[ucnt[1:0]] = '{repl: 1'b1, value: 8'h00};
                ucnt = ucnt + 3'd1;
            end
            else if (len == 3'd1)
            begin
                job.units[ucnt[1:0]] = '{repl: 1'b0, value: item.in_byte};
                ucnt = ucnt + 3'd1;
            end
            else
            begin
                pend_next[0] = item.in_byte;
                pcount_next  = 2'd1;
                seqlen_next  = len;
            end
        end

        // truncated sequence at stream end
        if (item.in_last)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (2'(k) < pcount_next)
                begin
                    job.units[ucnt[1:0]] = '{repl: 1'b1, value: 8'h00};
                    ucnt = ucnt + 3'd1;
                end
            end
            pcount_next = 2'd0;
            seqlen_next = 3'd0;
        end

        job.count = ucnt;
        job.last  = item.in_last;
    end

    assign push = accept && (ucnt != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= 2'd0;
            seqlen_reg <= 3'd0;
        end
        else if (accept)
        begin
            pcount_reg <= pcount_next;
            seqlen_reg <= seqlen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pend_reg[k] <= pend_next[k];
            end
        end
    end

endmodule

// ===== rtl/utf8s_queue.sv =====
`timescale 1ns / 1ps
// utf8s_queue: small job fifo between the front and back parts
// depends on utf8s_pkg

module utf8s_queue #(
    parameter int DEPTH = utf8s_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  utf8s_pkg::job_t      push_job,
    input  logic                 pop,
    output utf8s_pkg::job_t      head,
    output utf8s_pkg::q_status_t status
);
    import utf8s_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_pop;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign status.full      = (cnt_reg == CW'(DEPTH));
    assign status.not_empty = (cnt_reg != '0);
    assign head             = slot_reg[rd_ptr_reg];
    assign do_pop           = pop && status.not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (push && !do_pop)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (!push && do_pop)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/utf8s_back.sv =====
`timescale 1ns / 1ps
// utf8s_back: walks the head job unit by unit and drives the output register
// depends on utf8s_pkg

module utf8s_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  utf8s_pkg::job_t       head,
    input  utf8s_pkg::q_status_t  status,
    output logic                  pop,
    output logic                  valid,
    input  logic                  stall,
    output utf8s_pkg::out_item_t  data
);
    import utf8s_pkg::*;

    logic [1:0] unit_reg;
    logic [1:0] sub_reg;
    logic       valid_reg;
    out_item_t  data_reg;

    unit_t      cur;
    logic       load;
    logic       unit_done;
    logic       job_done;

    assign cur       = head.units[unit_reg];
    assign load      = status.not_empty && (!valid_reg || !stall);
    assign unit_done = !cur.repl || (sub_reg == SUB_B2);
    assign job_done  = unit_done && ({1'b0, unit_reg} == (head.count - 3'd1));
    assign pop       = load && job_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg  <= 2'd0;
            sub_reg   <= SUB_B0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                if (job_done)
                begin
                    unit_reg <= 2'd0;
                    sub_reg  <= SUB_B0;
                end
                else if (unit_done)
                begin
                    unit_reg <= unit_reg + 2'd1;
                    sub_reg  <= SUB_B0;
                end
                else
                begin
                    sub_reg <= sub_reg + 2'd1;
                end
            end
            else if (!stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg.out_byte     <= cur.repl ? repl_byte(sub_reg) : cur.value;
            data_reg.out_replaced <= cur.repl;
            data_reg.run_last     <= job_done;
            data_reg.stream_end   <= job_done && head.last;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ===== rtl/utf8_sanitizer.sv =====
`timescale 1ns / 1ps
// utf8_sanitizer: top level of the strict utf8 checker with U+FFFD substitution
// depends on utf8s_pkg, utf8s_front, utf8s_queue and utf8s_back

// Takes one byte per cycle on the byte channel while byte_stall is low and gives one
// byte per cycle on the text channel while text_stall is low. Well-formed text passes
// through with one output byte per input byte; the bytes of a multi-byte character come
// out together once its final byte arrives. An input item yields from 0 to 12 output
// bytes, and the back end's output register sends exactly one of them per cycle while
// text_stall is low; the front keeps taking input until the job queue (QueueDepth
// entries) fills. The first byte an item causes goes through the job queue and then the
// back end's output register. Each rejected held byte or invalid lead becomes EF BF BD
// with out_replaced set; run_last marks the last byte caused by one input item and
// stream_end the last byte of a stream. No reset sweep: items are taken at once.

module utf8_sanitizer #(
    parameter int QueueDepth = utf8s_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  utf8s_pkg::in_item_t  byte_data,
    output logic                 text_valid,
    input  logic                 text_stall,
    output utf8s_pkg::out_item_t text_data
);
    import utf8s_pkg::*;

    logic      accept;
    logic      q_push;
    logic      q_pop;
    job_t      new_job;
    job_t      head_job;
    q_status_t q_stat;

    assign byte_stall = q_stat.full;
    assign accept     = byte_valid && !byte_stall;

    utf8s_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (byte_data),
        .push   (q_push),
        .job    (new_job)
    );

    utf8s_queue #(
        .DEPTH (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (new_job),
        .pop      (q_pop),
        .head     (head_job),
        .status   (q_stat)
    );

    utf8s_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head_job),
        .status (q_stat),
        .pop    (q_pop),
        .valid  (text_valid),
        .stall  (text_stall),
        .data   (text_data)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("job pushed into a full queue");

    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> accept)
        else $error("job pushed without an accepted item");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_stat.not_empty)
        else $error("job popped from an empty queue");

    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (text_valid && text_data.stream_end) |-> text_data.run_last)
        else $error("stream end without end of run");

endmodule
